// ----- rtl/fly_camera_basis_update_assert.svh -----
// assertion helpers for the fly camera block
`ifndef FLY_CAMERA_BASIS_UPDATE_ASSERT_SVH
`define FLY_CAMERA_BASIS_UPDATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fly camera check failed");

// next-cycle implication, checked out of reset
`define FCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fly camera check failed");

`endif

// ----- rtl/fcb_pkg.sv -----
package fcb_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

    localparam int TURN_Q8          = 92160;
    localparam int HALF_TURN_Q8     = 46080;
    localparam int QUARTER_TURN_Q8  = 23040;
    localparam int PITCH_LIMIT_Q8   = 22784;
    localparam int ONE_Q14          = 16384;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // taylor series denominators (2k)(2k+1) for k = 1..6
    localparam longint unsigned TAYLOR_DEN [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156};

    // reciprocal of a full turn, exact for every quotient taken here
    localparam int RECIP_SHIFT = 46;
    localparam longint unsigned RECIP_TURN =
        ((64'd1 << RECIP_SHIFT) + 64'(TURN_Q8) - 64'd1) / 64'(TURN_Q8);
    // bias that keeps the wrap numerator positive
    localparam int WRAP_BIAS = HALF_TURN_Q8 + 256 * TURN_Q8;

    localparam logic [2:0] KIND_FORWARD  = 3'd0;
    localparam logic [2:0] KIND_BACKWARD = 3'd1;
    localparam logic [2:0] KIND_RIGHT    = 3'd2;
    localparam logic [2:0] KIND_LEFT     = 3'd3;
    localparam logic [2:0] KIND_MOUSE    = 3'd4;

    localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
    localparam logic [2:0] CFG_MOUSE_GAIN  = 3'd1;
    localparam logic [2:0] CFG_LIMIT_PITCH = 3'd2;
    localparam logic [2:0] CFG_START_X     = 3'd3;
    localparam logic [2:0] CFG_START_Y     = 3'd4;
    localparam logic [2:0] CFG_START_Z     = 3'd5;
    localparam logic [2:0] CFG_START_YAW   = 3'd6;
    localparam logic [2:0] CFG_START_PITCH = 3'd7;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } mul_req_t;

    typedef logic signed [15:0] sine_lut_t [SINE_TABLE_DEPTH];

    function automatic logic signed [15:0] quarter_sine(input longint unsigned n);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint          sum;
        x   = (n * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            mag = ((mag * x2) >> 30) / TAYLOR_DEN[k];
            if ((k % 2) == 1)
                sum = sum - longint'(mag);
            else
                sum = sum + longint'(mag);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 64'sd32768) >>> 16;
        if (sum > ONE_Q14)
            sum = ONE_Q14;
        return 16'(sum);
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        int quad;
        int r;
        logic signed [15:0] v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            quad = (4 * k) / SINE_TABLE_DEPTH;
            r    = 4 * k - quad * SINE_TABLE_DEPTH;
            if (quad == 0 || quad == 2)
                v = quarter_sine(64'(r));
            else
                v = quarter_sine(64'(SINE_TABLE_DEPTH - r));
            lut[k] = (quad >= 2) ? 16'(-v) : v;
        end
        return lut;
    endfunction

endpackage

// ----- rtl/fcb_mul.sv -----
module fcb_mul (
    input  logic                clk,
    input  fcb_pkg::mul_req_t   req,
    output logic signed [65:0]  prod_reg
);
    import fcb_pkg::*;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

endmodule

// ----- rtl/fcb_sine_rom.sv -----
module fcb_sine_rom (
    input  logic                      clk,
    input  logic [fcb_pkg::IDX_W-1:0] addr,
    output logic signed [15:0]        data_reg
);
    import fcb_pkg::*;

    localparam sine_lut_t LUT = build_sine_lut();

    always_ff @(posedge clk)
    begin
        data_reg <= LUT[addr];
    end

endmodule

// ----- rtl/fly_camera_basis_update.sv -----
// a move takes its distance, then steps the three position axes; a mouse event turns
// yaw and pitch, wraps yaw (pitch too if unlimited), rebuilds the basis; others finish
// throughput: one event at a time, in_stall stays high until the result is loaded,
// set by the single shared 33x33 multiplier and the registered sine table port
// reset: asynchronous, loads the reset register values and then rebuilds the basis, input
// stalled meanwhile
`include "fly_camera_basis_update_assert.svh"

module fly_camera_basis_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [15:0]        frame_time,
    input  logic [15:0]        pointer_x,
    input  logic [15:0]        pointer_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] front_x,
    output logic signed [15:0] front_y,
    output logic signed [15:0] front_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);
    import fcb_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_M_DIST  = 17'h00002,
        ST_M_LATCH = 17'h00004,
        ST_M_ISSUE = 17'h00008,
        ST_M_ACC   = 17'h00010,
        ST_P_DELTA = 17'h00020,
        ST_P_YAW   = 17'h00040,
        ST_P_PITCH = 17'h00080,
        ST_W_MOD   = 17'h00100,
        ST_W_QUO   = 17'h00200,
        ST_W_REM   = 17'h00400,
        ST_B_IDX   = 17'h00800,
        ST_B_ROM   = 17'h01000,
        ST_B_GET   = 17'h02000,
        ST_B_MUL   = 17'h04000,
        ST_B_TAKE  = 17'h08000,
        ST_FINISH  = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]        speed_reg, gain_reg;
    logic               limit_reg;
    logic signed [31:0] start_x_reg, start_y_reg, start_z_reg;
    logic signed [16:0] start_yaw_reg, start_pitch_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [17:0] yaw_reg, pitch_reg;
    logic [15:0]        last_x_reg, last_y_reg;
    logic               seen_reg;
    logic signed [15:0] fx_reg, fy_reg, fz_reg, rx_reg, rz_reg, ux_reg, uy_reg, uz_reg;
    logic signed [15:0] trig_reg [4];

    logic [2:0]         kind_reg;
    logic [15:0]        ft_reg, px_reg, py_reg;
    logic signed [32:0] dist_reg;
    logic signed [16:0] dy_reg;
    logic signed [26:0] wsrc_reg, pstep_reg;
    logic [26:0]        wu_reg;
    logic               wtgt_reg, pend_reg, cfg_run_reg;
    logic [1:0]         cnt_reg;

    logic signed [31:0] opos_reg [3];
    logic signed [15:0] ofx_reg, ofy_reg, ofz_reg, orx_reg, orz_reg;
    logic signed [15:0] oux_reg, ouy_reg, ouz_reg;
    logic               out_valid_reg;

    mul_req_t           mreq;
    logic signed [65:0] prod;
    logic [IDX_W-1:0]   rom_addr;
    logic signed [15:0] rom_data;

    fcb_mul u_mul (
        .clk      (clk),
        .req      (mreq),
        .prod_reg (prod)
    );

    fcb_sine_rom u_rom (
        .clk      (clk),
        .addr     (rom_addr),
        .data_reg (rom_data)
    );

    // handshakes
    logic       cfg_wr, ang_wr, in_acc, out_free, is_move;
    logic [2:0] cfg_idx;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign cfg_idx  = paddr[4:2];
    assign ang_wr   = cfg_wr && (cfg_idx == CFG_START_YAW || cfg_idx == CFG_START_PITCH);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign is_move  = (kind == KIND_FORWARD || kind == KIND_BACKWARD ||
                       kind == KIND_RIGHT || kind == KIND_LEFT);

    always_comb
    begin
        case (cfg_idx)
            CFG_MOVE_SPEED:  prdata = {16'd0, speed_reg};
            CFG_MOUSE_GAIN:  prdata = {16'd0, gain_reg};
            CFG_LIMIT_PITCH: prdata = {31'd0, limit_reg};
            CFG_START_X:     prdata = start_x_reg;
            CFG_START_Y:     prdata = start_y_reg;
            CFG_START_Z:     prdata = start_z_reg;
            CFG_START_YAW:   prdata = 32'(start_yaw_reg);
            CFG_START_PITCH: prdata = 32'(start_pitch_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // rounded views of the product
    logic signed [65:0] rnd8, rnd14, rnd22;
    logic signed [26:0] step8;
    logic signed [15:0] q14;
    logic signed [33:0] d22;
    assign rnd8  = prod + 66'sd128;
    assign rnd14 = prod + 66'sd8192;
    assign rnd22 = prod + 66'sd2097152;
    assign step8 = rnd8[34:8];
    assign q14   = rnd14[29:14];
    assign d22   = rnd22[55:22];

    // move operand and saturating accumulate
    logic signed [15:0] vsel;
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;
    always_comb
    begin
        case (cnt_reg)
            2'd0:    vsel = kind_reg[1] ? rx_reg : fx_reg;
            2'd1:    vsel = kind_reg[1] ? 16'sd0 : fy_reg;
            default: vsel = kind_reg[1] ? rz_reg : fz_reg;
        endcase
        pos_sum = 34'(pos_reg[cnt_reg]) + (kind_reg[0] ? -d22 : d22);
        if (pos_sum > 34'sd2147483647)
            pos_sat = 32'sh7fffffff;
        else if (pos_sum < -34'sd2147483648)
            pos_sat = 32'sh80000000;
        else
            pos_sat = pos_sum[31:0];
    end

    // mouse deltas, the first event sees a zero delta
    logic [15:0]        lx, ly;
    logic signed [16:0] dx, dy;
    logic signed [26:0] ysum, psum;
    logic signed [17:0] pclamp;
    assign lx   = seen_reg ? last_x_reg : px_reg;
    assign ly   = seen_reg ? last_y_reg : py_reg;
    assign dx   = $signed({1'b0, px_reg}) - $signed({1'b0, lx});
    assign dy   = $signed({1'b0, ly}) - $signed({1'b0, py_reg});
    assign ysum = 27'(yaw_reg) + step8;
    assign psum = 27'(pitch_reg) + step8;
    always_comb
    begin
        if (psum > 27'(PITCH_LIMIT_Q8))
            pclamp = 18'(PITCH_LIMIT_Q8);
        else if (psum < -27'(PITCH_LIMIT_Q8))
            pclamp = -18'(PITCH_LIMIT_Q8);
        else
            pclamp = psum[17:0];
    end

    // wrap by reciprocal quotient
    logic signed [27:0] wu_full;
    logic [9:0]         wq;
    logic [26:0]        wr;
    logic signed [17:0] wres;
    assign wu_full = 28'(wsrc_reg) + 28'(WRAP_BIAS);
    assign wq      = prod[RECIP_SHIFT +: 10];
    assign wr      = wu_reg - prod[26:0];
    assign wres    = $signed({1'b0, wr[16:0]}) - 18'(HALF_TURN_Q8);

    // table index of the angle in hand
    logic signed [18:0] ang;
    logic [16:0]        m;
    logic [32:0]        num;
    logic [IDX_W:0]     idx_full;
    always_comb
    begin
        case (cnt_reg)
            2'd0:    ang = 19'(yaw_reg);
            2'd1:    ang = 19'(yaw_reg) + 19'(QUARTER_TURN_Q8);
            2'd2:    ang = 19'(pitch_reg);
            default: ang = 19'(pitch_reg) + 19'(QUARTER_TURN_Q8);
        endcase
        if (ang < 0)
            m = 17'(ang + 19'(TURN_Q8));
        else if (ang >= 19'(TURN_Q8))
            m = 17'(ang - 19'(TURN_Q8));
        else
            m = ang[16:0];
        num      = 33'(m) * 33'(SINE_TABLE_DEPTH) + 33'(HALF_TURN_Q8);
        idx_full = prod[RECIP_SHIFT +: IDX_W + 1];
        if (idx_full >= (IDX_W + 1)'(SINE_TABLE_DEPTH))
            idx_full = idx_full - (IDX_W + 1)'(SINE_TABLE_DEPTH);
        rom_addr = idx_full[IDX_W-1:0];
    end

    // sign of cos pitch, zero counts as positive
    logic               neg_s;
    logic signed [15:0] sy, cy, sp, cp;
    assign sy    = trig_reg[0];
    assign cy    = trig_reg[1];
    assign sp    = trig_reg[2];
    assign cp    = trig_reg[3];
    assign neg_s = cp[15];

    always_comb
    begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            ST_M_DIST:
            begin
                mreq.a = 33'(speed_reg);
                mreq.b = 33'(ft_reg);
            end
            ST_M_ISSUE:
            begin
                mreq.a = dist_reg;
                mreq.b = 33'(vsel);
            end
            ST_P_DELTA:
            begin
                mreq.a = 33'(dx);
                mreq.b = 33'(gain_reg);
            end
            ST_P_YAW:
            begin
                mreq.a = 33'(dy_reg);
                mreq.b = 33'(gain_reg);
            end
            ST_W_MOD:
            begin
                mreq.a = 33'(wu_full);
                mreq.b = 33'(RECIP_TURN);
            end
            ST_W_QUO:
            begin
                mreq.a = 33'(wq);
                mreq.b = 33'(TURN_Q8);
            end
            ST_B_IDX:
            begin
                mreq.a = $signed(num);
                mreq.b = 33'(RECIP_TURN);
            end
            ST_B_MUL:
            begin
                mreq.a = 33'(cnt_reg[0] ? sy : cy);
                mreq.b = 33'(cnt_reg[1] ? sp : cp);
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_move)
                        state_next = ST_M_DIST;
                    else if (kind == KIND_MOUSE)
                        state_next = ST_P_DELTA;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_M_DIST:  state_next = ST_M_LATCH;
            ST_M_LATCH: state_next = ST_M_ISSUE;
            ST_M_ISSUE: state_next = ST_M_ACC;
            ST_M_ACC:   state_next = (cnt_reg == 2'd2) ? ST_FINISH : ST_M_ISSUE;
            ST_P_DELTA: state_next = ST_P_YAW;
            ST_P_YAW:   state_next = ST_P_PITCH;
            ST_P_PITCH: state_next = ST_W_MOD;
            ST_W_MOD:   state_next = ST_W_QUO;
            ST_W_QUO:   state_next = ST_W_REM;
            ST_W_REM:   state_next = pend_reg ? ST_W_MOD : ST_B_IDX;
            ST_B_IDX:   state_next = ST_B_ROM;
            ST_B_ROM:   state_next = ST_B_GET;
            ST_B_GET:   state_next = (cnt_reg == 2'd3) ? ST_B_MUL : ST_B_IDX;
            ST_B_MUL:   state_next = ST_B_TAKE;
            ST_B_TAKE:
            begin
                if (cnt_reg != 2'd3)
                    state_next = ST_B_MUL;
                else
                    state_next = cfg_run_reg ? ST_IDLE : ST_FINISH;
            end
            ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
        // an angle reload restarts the wrap and basis build
        if (ang_wr)
            state_next = ST_W_MOD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_B_IDX;
            cnt_reg         <= 2'd0;
            cfg_run_reg     <= 1'b1;
            pend_reg        <= 1'b0;
            wtgt_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            seen_reg        <= 1'b0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            speed_reg       <= 16'd1280;
            gain_reg        <= 16'd410;
            limit_reg       <= 1'b1;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_z_reg     <= '0;
            start_yaw_reg   <= -17'sd23040;
            start_pitch_reg <= '0;
            pos_reg[0]      <= '0;
            pos_reg[1]      <= '0;
            pos_reg[2]      <= '0;
            yaw_reg         <= -18'sd23040;
            pitch_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        kind_reg    <= kind;
                        ft_reg      <= frame_time;
                        px_reg      <= pointer_x;
                        py_reg      <= pointer_y;
                        cfg_run_reg <= 1'b0;
                        cnt_reg     <= 2'd0;
                    end
                end
                ST_M_LATCH:
                begin
                    dist_reg <= prod[32:0];
                    cnt_reg  <= 2'd0;
                end
                ST_M_ACC:
                begin
                    pos_reg[cnt_reg] <= pos_sat;
                    cnt_reg          <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                end
                ST_P_DELTA:
                begin
                    dy_reg     <= dy;
                    last_x_reg <= px_reg;
                    last_y_reg <= py_reg;
                    seen_reg   <= 1'b1;
                end
                ST_P_YAW:
                begin
                    wsrc_reg <= ysum;
                    wtgt_reg <= 1'b0;
                end
                ST_P_PITCH:
                begin
                    if (limit_reg)
                    begin
                        pitch_reg <= pclamp;
                        pend_reg  <= 1'b0;
                    end
                    else
                    begin
                        pstep_reg <= psum;
                        pend_reg  <= 1'b1;
                    end
                end
                ST_W_MOD:
                    wu_reg <= wu_full[26:0];
                ST_W_REM:
                begin
                    if (wtgt_reg)
                        pitch_reg <= wres;
                    else
                        yaw_reg <= wres;
                    if (pend_reg)
                    begin
                        wsrc_reg <= pstep_reg;
                        wtgt_reg <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                    cnt_reg <= 2'd0;
                end
                ST_B_GET:
                begin
                    trig_reg[cnt_reg] <= rom_data;
                    cnt_reg           <= cnt_reg + 2'd1;
                end
                ST_B_TAKE:
                begin
                    case (cnt_reg)
                        2'd0:    fx_reg <= q14;
                        2'd1:    fz_reg <= q14;
                        2'd2:    ux_reg <= neg_s ? q14 : 16'(-q14);
                        default:
                        begin
                            uz_reg <= neg_s ? q14 : 16'(-q14);
                            fy_reg <= sp;
                            rx_reg <= neg_s ? sy : 16'(-sy);
                            rz_reg <= neg_s ? 16'(-cy) : cy;
                            uy_reg <= neg_s ? 16'(-cp) : cp;
                        end
                    endcase
                    cnt_reg <= cnt_reg + 2'd1;
                end
                default:
                begin
                end
            endcase

            // result beat
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
                opos_reg[0]   <= pos_reg[0];
                opos_reg[1]   <= pos_reg[1];
                opos_reg[2]   <= pos_reg[2];
                ofx_reg       <= fx_reg;
                ofy_reg       <= fy_reg;
                ofz_reg       <= fz_reg;
                orx_reg       <= rx_reg;
                orz_reg       <= rz_reg;
                oux_reg       <= ux_reg;
                ouy_reg       <= uy_reg;
                ouz_reg       <= uz_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                case (cfg_idx)
                    CFG_MOVE_SPEED:  speed_reg <= pwdata[15:0];
                    CFG_MOUSE_GAIN:  gain_reg  <= pwdata[15:0];
                    CFG_LIMIT_PITCH: limit_reg <= pwdata[0];
                    CFG_START_X:
                    begin
                        start_x_reg <= pwdata;
                        pos_reg[0]  <= pwdata;
                    end
                    CFG_START_Y:
                    begin
                        start_y_reg <= pwdata;
                        pos_reg[1]  <= pwdata;
                    end
                    CFG_START_Z:
                    begin
                        start_z_reg <= pwdata;
                        pos_reg[2]  <= pwdata;
                    end
                    CFG_START_YAW:
                    begin
                        start_yaw_reg <= pwdata[16:0];
                        wsrc_reg      <= 27'($signed(pwdata[16:0]));
                        wtgt_reg      <= 1'b0;
                        pend_reg      <= 1'b0;
                        cfg_run_reg   <= 1'b1;
                    end
                    CFG_START_PITCH:
                    begin
                        start_pitch_reg <= pwdata[16:0];
                        wsrc_reg        <= 27'($signed(pwdata[16:0]));
                        wtgt_reg        <= 1'b1;
                        pend_reg        <= 1'b0;
                        cfg_run_reg     <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = opos_reg[0];
    assign pos_y     = opos_reg[1];
    assign pos_z     = opos_reg[2];
    assign front_x   = ofx_reg;
    assign front_y   = ofy_reg;
    assign front_z   = ofz_reg;
    assign right_x   = orx_reg;
    assign right_y   = 16'sd0;
    assign right_z   = orz_reg;
    assign up_x      = oux_reg;
    assign up_y      = ouy_reg;
    assign up_z      = ouz_reg;

    `FCB_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
    `FCB_ASSERT_NEXT(a_finish_loads_result, state_reg == ST_FINISH && out_free, out_valid)
    `FCB_ASSERT_NEXT(a_move_keeps_angles, in_acc && is_move && !ang_wr,
        $stable(yaw_reg) && $stable(pitch_reg))

endmodule
